/* hdl/scbf_pkg.sv */
// Shared constants, types and CORDIC angle table of the spectral comb bin filter.
package scbf_pkg;

	// Sizes of the block.
	localparam int MAX_BINS      = 4096;
	localparam int CORDIC_STAGES = 16;
	localparam int LATENCY       = 2 * CORDIC_STAGES + 8;

	// Datapath widths.
	localparam int ROT_W = 36;
	localparam int ANG_W = 34;
	localparam int MUL_W = 33;
	localparam int VIN_W = 34;
	localparam int VEC_W = 36;

	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [MUL_W-1:0] mul_t;
	typedef logic signed [VIN_W-1:0] vin_t;
	typedef logic signed [VEC_W-1:0] vec_t;

	// Reciprocal of the CORDIC gain, Q0.31, and the pre-scaled unit vector.
	localparam logic signed [31:0]      INV_GAIN = 32'sh4DBA76D4;
	localparam logic signed [ROT_W-1:0] UNIT_X0  = 36'sh026DD3B6A;

	// Arctangent of 2^-i in Q0.32 turns.
	localparam logic [31:0] ATAN_TURNS [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

/* hdl/scbf_rot_cordic.sv */
// Pipelined rotation CORDIC, one register stage per iteration.
module scbf_rot_cordic (
	input  logic          clk,
	input  scbf_pkg::rot_t x0,
	input  scbf_pkg::ang_t z0,
	output scbf_pkg::rot_t x,
	output scbf_pkg::rot_t y
);
	import scbf_pkg::*;

	rot_t x_s [CORDIC_STAGES];
	rot_t y_s [CORDIC_STAGES];
	ang_t z_s [CORDIC_STAGES];

	// Each stage turns the vector towards a residual angle of zero.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		rot_t xi;
		rot_t yi;
		ang_t zi;
		ang_t step;

		if (i == 0) begin : g_first
			assign xi = x0;
			assign yi = '0;
			assign zi = z0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end

		assign step = signed'({2'b00, ATAN_TURNS[i]});

		always_ff @(posedge clk) begin
			if (!zi[ANG_W-1]) begin
				x_s[i] <= xi - (yi >>> i);
				y_s[i] <= yi + (xi >>> i);
				z_s[i] <= zi - step;
			end else begin
				x_s[i] <= xi + (yi >>> i);
				y_s[i] <= yi - (xi >>> i);
				z_s[i] <= zi + step;
			end
		end
	end

	assign x = x_s[CORDIC_STAGES-1];
	assign y = y_s[CORDIC_STAGES-1];

endmodule

/* hdl/scbf_vec_cordic.sv */
// Pipelined vectoring CORDIC with half-turn pre-fold, giving length and angle.
module scbf_vec_cordic (
	input  logic           clk,
	input  scbf_pkg::vin_t x0,
	input  scbf_pkg::vin_t y0,
	output scbf_pkg::vec_t x,
	output logic [31:0]    z,
	output logic           zero
);
	import scbf_pkg::*;

	vec_t        xf_s0;
	vec_t        yf_s0;
	logic [31:0] zf_s0;
	logic        zr_s0;

	vec_t        x_s  [CORDIC_STAGES];
	vec_t        y_s  [CORDIC_STAGES];
	logic [31:0] z_s  [CORDIC_STAGES];
	logic        zr_s [CORDIC_STAGES];

	// A vector in the left half plane is turned by a half turn first.
	always_ff @(posedge clk) begin
		zr_s0 <= (x0 == '0) && (y0 == '0);
		if (x0[VIN_W-1]) begin
			xf_s0 <= -vec_t'(x0);
			yf_s0 <= -vec_t'(y0);
			zf_s0 <= 32'h80000000;
		end else begin
			xf_s0 <= vec_t'(x0);
			yf_s0 <= vec_t'(y0);
			zf_s0 <= '0;
		end
	end

	// Each stage drives the imaginary part towards zero and sums the angle.
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		vec_t        xi;
		vec_t        yi;
		logic [31:0] zi;
		logic        zri;

		if (i == 0) begin : g_first
			assign xi  = xf_s0;
			assign yi  = yf_s0;
			assign zi  = zf_s0;
			assign zri = zr_s0;
		end else begin : g_next
			assign xi  = x_s[i-1];
			assign yi  = y_s[i-1];
			assign zi  = z_s[i-1];
			assign zri = zr_s[i-1];
		end

		always_ff @(posedge clk) begin
			zr_s[i] <= zri;
			if (yi[VEC_W-1]) begin
				x_s[i] <= xi - (yi >>> i);
				y_s[i] <= yi + (xi >>> i);
				z_s[i] <= zi - ATAN_TURNS[i];
			end else begin
				x_s[i] <= xi + (yi >>> i);
				y_s[i] <= yi - (xi >>> i);
				z_s[i] <= zi + ATAN_TURNS[i];
			end
		end
	end

	assign x    = x_s[CORDIC_STAGES-1];
	assign z    = z_s[CORDIC_STAGES-1];
	assign zero = zr_s[CORDIC_STAGES-1];

endmodule

/* hdl/spectral_comb_bin_filter.sv */
// Top level of the spectral comb bin filter: comb weighting of polar spectrum bins.
//
// Usage: an item (one spectrum bin: index, linear magnitude, phase) is taken at
// each rising edge where start is high and busy is low. busy is always low, so
// an item may be offered in every cycle. Each item leaves as one result on
// out_magnitude, out_phase and out_index, marked by done for exactly one cycle.
// Throughput is one item per cycle; the two rotation CORDICs, the complex
// multiply and the vectoring CORDIC are fully pipelined, one iteration a stage.
// The user must write the phase step register through phase_step_we and
// phase_step only while no item is in flight; the block does not enforce it.
// A zero step or a bin index of MAX_BINS or more gives no result for that item.
// Reset clears the phase step and all items in flight; no clearing pass runs.
// The receiver cannot stall: each result must be taken in the cycle shown.
module spectral_comb_bin_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] bin_index,
	input  logic [15:0] bin_magnitude,
	input  logic signed [15:0] bin_phase,
	input  logic        phase_step_we,
	input  logic [31:0] phase_step,
	output logic        done,
	output logic [15:0] out_magnitude,
	output logic signed [15:0] out_phase,
	output logic [11:0] out_index
);
	import scbf_pkg::*;

	logic [31:0] phase_step_q;
	logic        vld_q [LATENCY];
	logic [11:0] idx_q [LATENCY];
	logic        entry;

	logic [43:0] comb_prod;
	logic [31:0] ang_s1;
	logic [15:0] mag_s1;
	logic [15:0] ph_s1;

	logic        cfold;
	logic [31:0] cang;
	logic [31:0] bang;
	logic        bfold;
	logic [31:0] bang_f;
	logic signed [31:0] bv;
	logic signed [31:0] bvn;
	logic signed [63:0] bp;
	logic signed [63:0] bsum;
	rot_t cx_s2;
	ang_t cz_s2;
	rot_t bx_s2;
	ang_t bz_s2;

	rot_t cq;
	rot_t sq;
	rot_t re;
	rot_t im;
	rot_t crs;
	rot_t cis;
	mul_t cr_s3;
	mul_t ci_s3;
	mul_t re_s3;
	mul_t im_s3;

	logic signed [2*MUL_W-1:0] prr_s4;
	logic signed [2*MUL_W-1:0] pii_s4;
	logic signed [2*MUL_W-1:0] pri_s4;
	logic signed [2*MUL_W-1:0] pir_s4;

	logic signed [2*MUL_W:0] nr_sum;
	logic signed [2*MUL_W:0] ni_sum;
	vin_t nr_s5;
	vin_t ni_s5;

	vec_t        vx;
	logic [31:0] vz;
	logic        vzero;
	logic signed [VEC_W+31:0] gp;
	logic signed [VEC_W+31:0] gsum;
	logic signed [37:0] m1_s6;
	logic [31:0] z_s6;
	logic        zero_s6;

	logic signed [37:0] m2;
	logic [31:0] zr;
	logic [15:0] mag_s7;
	logic [15:0] ph_s7;

	// The block never holds items off.
	assign busy  = 1'b0;
	assign entry = start && !busy && (phase_step_q != '0) && (32'(bin_index) < MAX_BINS);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
		end else if (phase_step_we) begin
			phase_step_q <= phase_step;
		end
	end

	// Valid bits and bin indices travel alongside the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LATENCY; k++) vld_q[k] <= 1'b0;
		end else begin
			vld_q[0] <= entry;
			for (int k = 1; k < LATENCY; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		idx_q[0] <= bin_index;
		for (int k = 1; k < LATENCY; k++) idx_q[k] <= idx_q[k-1];
	end

	// Stage 1: comb angle of the bin, modulo one turn.
	assign comb_prod = 44'(bin_index) * 44'(phase_step_q);

	always_ff @(posedge clk) begin
		ang_s1 <= comb_prod[31:0];
		mag_s1 <= bin_magnitude;
		ph_s1  <= bin_phase;
	end

	// Stage 2: fold both angles into the right half plane, scale the bin magnitude.
	assign cfold  = ang_s1[30] ^ ang_s1[31];
	assign cang   = {ang_s1[31] ^ cfold, ang_s1[30:0]};
	assign bang   = {ph_s1, 16'h0000};
	assign bfold  = bang[30] ^ bang[31];
	assign bang_f = {bang[31] ^ bfold, bang[30:0]};
	assign bv     = signed'({2'b00, mag_s1, 14'h0000});
	assign bvn    = bfold ? -bv : bv;
	assign bp     = 64'(bvn) * 64'(INV_GAIN);
	assign bsum   = bp + (64'sd1 <<< 30);

	always_ff @(posedge clk) begin
		cx_s2 <= cfold ? -UNIT_X0 : UNIT_X0;
		cz_s2 <= ang_t'(signed'(cang));
		bx_s2 <= rot_t'(bsum >>> 31);
		bz_s2 <= ang_t'(signed'(bang_f));
	end

	// Comb cosine and sine, and the bin in rectangular form.
	scbf_rot_cordic u_comb_rot (
		.clk (clk),
		.x0  (cx_s2),
		.z0  (cz_s2),
		.x   (cq),
		.y   (sq)
	);

	scbf_rot_cordic u_bin_rot (
		.clk (clk),
		.x0  (bx_s2),
		.z0  (bz_s2),
		.x   (re),
		.y   (im)
	);

	// Stage 3: comb weights (1 + cos) / 2 and (1 - sin) / 2.
	assign crs = ((rot_t'(1) <<< 30) + cq) >>> 1;
	assign cis = ((rot_t'(1) <<< 30) - sq) >>> 1;

	always_ff @(posedge clk) begin
		cr_s3 <= mul_t'(crs);
		ci_s3 <= mul_t'(cis);
		re_s3 <= mul_t'(re);
		im_s3 <= mul_t'(im);
	end

	// Stage 4: the four partial products of the complex multiply.
	always_ff @(posedge clk) begin
		prr_s4 <= re_s3 * cr_s3;
		pii_s4 <= im_s3 * ci_s3;
		pri_s4 <= re_s3 * ci_s3;
		pir_s4 <= im_s3 * cr_s3;
	end

	// Stage 5: sums, rounded back to Q.30.
	assign nr_sum = (2*MUL_W+1)'(prr_s4) - (2*MUL_W+1)'(pii_s4) + ((2*MUL_W+1)'(1) <<< 29);
	assign ni_sum = (2*MUL_W+1)'(pri_s4) + (2*MUL_W+1)'(pir_s4) + ((2*MUL_W+1)'(1) <<< 29);

	always_ff @(posedge clk) begin
		nr_s5 <= vin_t'(nr_sum >>> 30);
		ni_s5 <= vin_t'(ni_sum >>> 30);
	end

	// Back to polar form.
	scbf_vec_cordic u_polar (
		.clk  (clk),
		.x0   (nr_s5),
		.y0   (ni_s5),
		.x    (vx),
		.z    (vz),
		.zero (vzero)
	);

	// Stage 6: remove the CORDIC gain from the length.
	assign gp   = (VEC_W+32)'(vx) * (VEC_W+32)'(INV_GAIN);
	assign gsum = gp + ((VEC_W+32)'(1) <<< 30);

	always_ff @(posedge clk) begin
		m1_s6   <= 38'(gsum >>> 31);
		z_s6    <= vz;
		zero_s6 <= vzero;
	end

	// Stage 7: round and saturate the magnitude, round the phase.
	assign m2 = (m1_s6 + (38'sd1 <<< 13)) >>> 14;
	assign zr = z_s6 + 32'h00008000;

	always_ff @(posedge clk) begin
		if (m2[37]) begin
			mag_s7 <= '0;
		end else if (m2 > 38'sd65535) begin
			mag_s7 <= 16'hFFFF;
		end else begin
			mag_s7 <= m2[15:0];
		end
		ph_s7 <= zero_s6 ? 16'h0000 : zr[31:16];
	end

	assign done          = vld_q[LATENCY-1];
	assign out_index     = idx_q[LATENCY-1];
	assign out_magnitude = mag_s7;
	assign out_phase     = signed'(ph_s7);

	// A result always comes from an item that was taken with start high.
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without an item taken LATENCY cycles before");

	a_index_kept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_index == $past(bin_index, LATENCY))
		else $error("bin index not carried with its result");

	a_comb_on: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(phase_step_q != '0, LATENCY))
		else $error("result produced while the comb was off");

endmodule

/* test/spectral_comb_bin_filter_check.sv */
// Checker for the spectral comb bin filter: predicts each bin's result and compares it.
`timescale 1ns / 100ps
module spectral_comb_bin_filter_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [11:0]        bin_index,
	input  logic [15:0]        bin_magnitude,
	input  logic signed [15:0] bin_phase,
	input  logic               phase_step_we,
	input  logic [31:0]        phase_step,
	input  logic               done,
	input  logic [15:0]        out_magnitude,
	input  logic signed [15:0] out_phase,
	input  logic [11:0]        out_index,
	output int                 fail_count,
	output int                 pending
);
	import scbf_pkg::*;

	typedef struct packed {
		logic [15:0] mag;
		logic [15:0] ph;
		logic [11:0] idx;
	} bin_result_t;

	bin_result_t expected_bins[$];
	logic [31:0] comb_step;

	// Floor shift of a signed value.
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint scale_by_inv_gain(longint v);
		return floor_shr(v * longint'(INV_GAIN) + (64'sd1 <<< 30), 31);
	endfunction

	// Rotation CORDIC of a real start value by a Q0.32 turn angle.
	function automatic void cordic_rotate(input longint v, input logic [31:0] ang,
			output longint xo, output longint yo);
		longint x, y, z, dx, dy;
		if (ang[30] != ang[31]) begin
			ang = ang + 32'h80000000;
			v = -v;
		end
		z = longint'(signed'(ang));
		x = scale_by_inv_gain(v);
		y = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
			end
		end
		xo = x;
		yo = y;
	endfunction

	// Works out the filtered bin for one accepted item.
	function automatic bin_result_t comb_filter_bin(logic [11:0] idx, logic [15:0] mag,
			logic [15:0] ph);
		bin_result_t r;
		logic [31:0] comb_ang, z;
		longint cq, sq, cr, ci, re, im, nr, ni, dx, dy, m, half;
		comb_ang = 32'(longint'(idx) * longint'(comb_step));
		cordic_rotate(64'sd1 <<< 30, comb_ang, cq, sq);
		cr = floor_shr((64'sd1 <<< 30) + cq, 1);
		ci = floor_shr((64'sd1 <<< 30) - sq, 1);
		cordic_rotate(longint'(mag) <<< 14, {ph, 16'h0}, re, im);
		half = 64'sd1 <<< 29;
		nr = floor_shr(re * cr - im * ci + half, 30);
		ni = floor_shr(re * ci + im * cr + half, 30);
		r.idx = idx;
		if (nr == 0 && ni == 0) begin
			r.mag = 0;
			r.ph = 0;
			return r;
		end
		z = 0;
		if (nr < 0) begin
			nr = -nr;
			ni = -ni;
			z = 32'h80000000;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = floor_shr(ni, i);
			dy = floor_shr(nr, i);
			if (ni < 0) begin
				nr -= dx; ni += dy; z -= ATAN_TURNS[i];
			end else begin
				nr += dx; ni -= dy; z += ATAN_TURNS[i];
			end
		end
		m = floor_shr(scale_by_inv_gain(nr) + (64'sd1 <<< 13), 14);
		if (m < 0) m = 0;
		if (m > 65535) m = 65535;
		r.mag = 16'(m);
		z = z + 32'h8000;
		r.ph = z[31:16];
		return r;
	endfunction

	assign pending = expected_bins.size();

	// Register write, accepted items and results, all sampled at the rising edge.
	always_ff @(posedge clk or negedge arst_n) begin
		bin_result_t want, got;
		if (!arst_n) begin
			comb_step <= '0;
			fail_count <= 0;
			expected_bins.delete();
		end else begin
			if (phase_step_we)
				comb_step <= phase_step;
			if (start && !busy && comb_step != 0 && bin_index < MAX_BINS)
				expected_bins.push_back(comb_filter_bin(bin_index, bin_magnitude,
					bin_phase));
			if (done) begin
				got = '{out_magnitude, out_phase, out_index};
				if (expected_bins.size() == 0) begin
					if (fail_count < 10)
						$display("Unexpected result: mag %0d phase %0d index %0d",
							out_magnitude, out_phase, out_index);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_bins.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display({"Mismatch: expected mag %0d phase %0d index %0d,",
								" got mag %0d phase %0d index %0d"},
								want.mag, $signed(want.ph), want.idx,
								got.mag, $signed(got.ph), got.idx);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* test/spectral_comb_bin_filter_test.sv */
// Testbench top of the spectral comb bin filter: stimulus, register phases and verdict.
`timescale 1ns / 100ps
module spectral_comb_bin_filter_test;
	import scbf_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [11:0]        bin_index = '0;
	logic [15:0]        bin_magnitude = '0;
	logic signed [15:0] bin_phase = '0;
	logic               phase_step_we = 1'b0;
	logic [31:0]        phase_step = '0;
	logic               done;
	logic [15:0]        out_magnitude;
	logic signed [15:0] out_phase;
	logic [11:0]        out_index;
	int                 fail_count;
	int                 pending;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	spectral_comb_bin_filter DUT (.*);

	spectral_comb_bin_filter_check checker_i (.*);

	// Offers one item; with gaps on, it first idles while a draw of 26 in a hundred comes up.
	task automatic send_bin(input logic [11:0] idx, input logic [15:0] mag,
			input logic [15:0] ph, input bit gaps);
		while (gaps && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		bin_index <= idx;
		bin_magnitude <= mag;
		bin_phase <= ph;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Writes the step once all items have drained out of the pipeline.
	task automatic set_step(input logic [31:0] step);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		phase_step_we <= 1'b1;
		phase_step <= step;
		@(posedge clk);
		phase_step_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_mag();
		case ($urandom_range(3))
			0: return 16'hFFFF - 16'($urandom_range(7));
			1: return 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [31:0] steps [6];
		steps = '{32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h00100000, 32'h40000000, 32'h0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Comb off after reset: no results.
		send_bin(12'd5, 16'hFFFF, 16'h1234, 0);

		// Directed bins: field extremes and phases around the circle.
		set_step(32'h01000000);
		send_bin(12'd0, 16'hFFFF, 16'h0000, 0);
		send_bin(12'hFFF, 16'hFFFF, 16'h8000, 0);
		send_bin(12'd1, 16'h0000, 16'h7FFF, 0);
		send_bin(12'd128, 16'hFFFF, 16'h4000, 0);
		send_bin(12'd64, 16'h0001, 16'hC000, 0);
		send_bin(12'd32, 16'hFFFF, 16'h7FFF, 0);
		send_bin(12'd255, 16'h8000, 16'h8001, 0);
		send_bin(12'hAAA, 16'h5555, 16'h5555, 0);
		send_bin(12'h555, 16'hAAAA, 16'hAAAA, 0);
		// A half-turn comb step at index 1 drives the cosine weight towards zero.
		set_step(32'h80000000);
		send_bin(12'd1, 16'hFFFF, 16'h0000, 0);
		send_bin(12'd1, 16'h1234, 16'h2000, 0);
		send_bin(12'd2, 16'hFFFF, 16'hE000, 0);

		// Random phases over a spread of steps, extremes and step zero included.
		foreach (steps[s]) begin
			set_step(steps[s]);
			for (int n = 0; n < 75; n++)
				send_bin(12'($urandom), pick_mag(), 16'($urandom), !(s == 2 && n < 40));
			set_step($urandom);
			for (int n = 0; n < 8; n++)
				send_bin(12'($urandom), pick_mag(), 16'($urandom), 1);
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
